>>> hdl/rgb_to_hsv_converter_macros.svh
// Assertion macros shared by the RGB to HSV converter modules.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define RHC_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Implication checked in the same cycle.
`define RHC_ASSERT_IMP(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

>>> hdl/rhc_pkg.sv
// Package for the RGB to HSV converter: widths, constants, payload and stage types.
// Used by the divider pipeline and the top level; no dependencies.
package rhc_pkg;

	localparam int CHAN_W     = 8;
	localparam int CHAN_FULL  = 255;
	localparam int HUE_W      = 15;
	localparam int HUE_SECTOR = 3840;
	localparam int HUE_TURN   = 23040;

	// Reciprocal divider: quotient estimate is (num * floor(2^RCP_SHIFT / den)) >> RCP_SHIFT.
	localparam int RCP_SHIFT  = 20;
	localparam int RCP_W      = RCP_SHIFT + 1;
	localparam int HNUM_W     = 20;
	localparam int SNUM_W     = 16;
	localparam int HQ_W       = 12;
	localparam int REM_W      = CHAN_W + 1;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [CHAN_W-1:0] saturation;
		logic [CHAN_W-1:0] brightness;
	} hsv_t;

	// Per-pixel facts that ride along with the divisions.
	typedef struct packed {
		logic              grey;
		sector_t           sector;
		logic              neg;
		logic [CHAN_W-1:0] mx;
	} side_t;

	typedef struct packed {
		logic [HNUM_W-1:0] hnum;
		logic [SNUM_W-1:0] snum;
		logic [CHAN_W-1:0] delta;
		side_t             side;
	} div_in_t;

	typedef struct packed {
		logic [HQ_W-1:0]   hq;
		logic              hrem_nz;
		logic [CHAN_W-1:0] sq;
		side_t             side;
	} div_out_t;

endpackage

>>> hdl/rhc_stream_if.sv
// Valid/ready stream interface used for the pixel channels of the converter.
// The payload type is a parameter; the converter uses rgb_t and hsv_t from rhc_pkg.
interface rhc_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/rgb_to_hsv_converter.sv
// Top level of the RGB to HSV converter: front stage, divider pipeline, hue assembly.
// Depends on rhc_pkg, rhc_stream_if, rhc_div_pipe and the assertion macros header.
//
// Usage: pixels enter on the rgb channel and leave on the hsv channel, both
// valid/ready streams. A transfer happens on a rising edge with valid and ready
// both high. Every input transfer produces exactly one output transfer, in order.
// Brightness is the largest channel, saturation is floor(255*delta/max), and hue
// is given in 1/64 degree (0 to 23039). Grey pixels return hue and saturation 0.
// The design is a six-stage pipeline, and one pixel can enter every cycle
// while the receiver keeps ready high. That rate comes from the divider,
// which uses a reciprocal table, a multiplier and a one-step correction,
// each in its own stage, so no unit is shared between pixels.
// Reset empties the pipeline; no configuration is needed. When the receiver
// holds ready low, the output stage keeps its result and the stages behind it
// fill up, closing any bubbles; rgb.ready drops only when all six stages hold
// a pixel, and no pixel is lost or repeated.
`include "rgb_to_hsv_converter_macros.svh"

module rgb_to_hsv_converter (
	input  logic         clk,
	input  logic         arst_n,
	rhc_stream_if.sink   rgb,
	rhc_stream_if.source hsv
);
	import rhc_pkg::*;

	// Stage 1: max, delta, sector and the numerators of both divisions.
	logic [CHAN_W-1:0] r, g, b;
	logic [CHAN_W-1:0] mx, mn, delta;
	logic [CHAN_W-1:0] opa, opb, adiff;
	sector_t           sector;
	logic              neg;
	div_in_t           div_in;
	div_in_t           div_in_s1;
	logic              v_s1, en_s1;

	logic              div_ready;
	logic              div_valid;
	div_out_t          div_out;

	// Stage 6: hue assembly into the output register.
	logic              en_s6, v_s6;
	logic [HUE_W-1:0]  hq_ext;
	logic [HUE_W-1:0]  offset;
	logic [HUE_W-1:0]  hue_c;
	hsv_t              hsv_s6;

	assign r = rgb.data.red;
	assign g = rgb.data.green;
	assign b = rgb.data.blue;

	always_comb begin
		mx    = (r > g) ? r : g;
		mx    = (mx > b) ? mx : b;
		mn    = (r < g) ? r : g;
		mn    = (mn < b) ? mn : b;
		delta = mx - mn;

		// Red wins ties, then green; the hue difference follows the sector.
		if (r >= mx) begin
			sector = SEC_RED;
			opa    = g;
			opb    = b;
		end else if (g >= mx) begin
			sector = SEC_GREEN;
			opa    = b;
			opb    = r;
		end else begin
			sector = SEC_BLUE;
			opa    = r;
			opb    = g;
		end
		neg   = opa < opb;
		adiff = neg ? opb - opa : opa - opb;

		div_in.hnum        = HNUM_W'(adiff) * HNUM_W'(HUE_SECTOR);
		div_in.snum        = SNUM_W'(delta) * SNUM_W'(CHAN_FULL);
		div_in.delta       = delta;
		div_in.side.grey   = delta == '0;
		div_in.side.sector = sector;
		div_in.side.neg    = neg;
		div_in.side.mx     = mx;
	end

	assign en_s1     = !v_s1 || div_ready;
	assign rgb.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= rgb.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			div_in_s1 <= div_in;
		end
	end

	rhc_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (div_ready),
		.in_data   (div_in_s1),
		.out_valid (div_valid),
		.out_ready (en_s6),
		.out_data  (div_out)
	);

	// Green and blue sectors never wrap, as their offset exceeds any quotient, so their truncated hue is the
	// offset plus the floor of the signed quotient. The red sector truncates
	// toward zero first and wraps only a nonzero negative result.
	always_comb begin
		hq_ext = HUE_W'(div_out.hq);
		offset = '0;
		hue_c  = '0;
		case (div_out.side.sector)
			SEC_RED: begin
				if (div_out.side.neg && hq_ext != '0) begin
					hue_c = HUE_W'(HUE_TURN) - hq_ext;
				end else if (div_out.side.neg) begin
					hue_c = '0;
				end else begin
					hue_c = hq_ext;
				end
			end
			SEC_GREEN, SEC_BLUE: begin
				offset = (div_out.side.sector == SEC_GREEN) ?
					HUE_W'(2 * HUE_SECTOR) : HUE_W'(4 * HUE_SECTOR);
				if (div_out.side.neg) begin
					hue_c = offset - hq_ext - HUE_W'(div_out.hrem_nz);
				end else begin
					hue_c = offset + hq_ext;
				end
			end
			default: begin
				hue_c = '0;
			end
		endcase
		if (div_out.side.grey) begin
			hue_c = '0;
		end
	end

	assign en_s6 = !v_s6 || hsv.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en_s6) begin
			v_s6 <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			hsv_s6.hue        <= hue_c;
			hsv_s6.saturation <= div_out.side.grey ? '0 : div_out.sq;
			hsv_s6.brightness <= div_out.side.mx;
		end
	end

	assign hsv.valid = v_s6;
	assign hsv.data  = hsv_s6;

	`RHC_ASSERT_IMP(a_hue_range, v_s6, hsv_s6.hue < HUE_W'(HUE_TURN),
		"hue outside one full turn")
	`RHC_ASSERT_IMP(a_grey_hue, v_s6 && hsv_s6.saturation == '0, hsv_s6.hue == '0,
		"zero saturation with nonzero hue")
	`RHC_ASSERT(a_black_grey, !v_s6 || hsv_s6.brightness != '0 || hsv_s6.saturation == '0,
		"black pixel with nonzero saturation")

endmodule

>>> hdl/rhc_div_pipe.sv
// Four-stage reciprocal divider pipeline computing the hue and saturation quotients.
// Depends on rhc_pkg and on the assertion macros header.
`include "rgb_to_hsv_converter_macros.svh"

module rhc_div_pipe (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  rhc_pkg::div_in_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output rhc_pkg::div_out_t out_data
);
	import rhc_pkg::*;

	localparam int TBL_N  = 2 ** CHAN_W;
	localparam int HPRD_W = HNUM_W + RCP_W;
	localparam int SPRD_W = SNUM_W + RCP_W;
	localparam int HMUL_W = HQ_W + CHAN_W;
	localparam int SMUL_W = 2 * CHAN_W;

	// Reciprocal table, floor(2^RCP_SHIFT / d); entry zero only serves grey pixels.
	logic [RCP_W-1:0] recip_tbl [TBL_N];

	assign recip_tbl[0] = '0;
	for (genvar d = 1; d < TBL_N; d++) begin : g_rcp
		localparam logic [RCP_W-1:0] RCP = RCP_W'((1 << RCP_SHIFT) / d);
		assign recip_tbl[d] = RCP;
	end

	logic en_s2, en_s3, en_s4, en_s5;
	logic v_s2, v_s3, v_s4, v_s5;

	// Stage 2: reciprocal lookup.
	div_in_t          din_s2;
	logic [RCP_W-1:0] hrcp_s2, srcp_s2;

	// Stage 3: quotient estimates, at most one below the true quotient.
	logic [HPRD_W-1:0] hprod;
	logic [SPRD_W-1:0] sprod;
	logic [HQ_W-1:0]   hq0_s3;
	logic [CHAN_W-1:0] sq0_s3;
	logic [HNUM_W-1:0] hnum_s3;
	logic [SNUM_W-1:0] snum_s3;
	logic [CHAN_W-1:0] delta_s3;
	side_t             side_s3;

	// Stage 4: remainders of the estimates, below twice the divisor.
	logic [HMUL_W-1:0] hback;
	logic [SMUL_W-1:0] sback;
	logic [HNUM_W-1:0] hrem_full;
	logic [SNUM_W-1:0] srem_full;
	logic [HQ_W-1:0]   hq0_s4;
	logic [CHAN_W-1:0] sq0_s4;
	logic [REM_W-1:0]  hrem_s4, srem_s4;
	logic [CHAN_W-1:0] delta_s4;
	side_t             side_s4;

	// Stage 5: one correction step.
	logic              hfix, sfix;
	logic [REM_W-1:0]  hrem_c;
	logic [HQ_W-1:0]   hq_s5;
	logic [CHAN_W-1:0] sq_s5;
	logic [REM_W-1:0]  hrem_s5;
	logic [CHAN_W-1:0] delta_s5;
	side_t             side_s5;

	// A stage loads when it is empty or when the next one loads too.
	assign en_s5    = !v_s5 || out_ready;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign in_ready = en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s2) v_s2 <= in_valid;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	always_comb begin
		hprod     = HPRD_W'(din_s2.hnum) * HPRD_W'(hrcp_s2);
		sprod     = SPRD_W'(din_s2.snum) * SPRD_W'(srcp_s2);
		hback     = HMUL_W'(hq0_s3) * HMUL_W'(delta_s3);
		sback     = SMUL_W'(sq0_s3) * SMUL_W'(side_s3.mx);
		hrem_full = hnum_s3 - HNUM_W'(hback);
		srem_full = snum_s3 - SNUM_W'(sback);
		hfix      = hrem_s4 >= REM_W'(delta_s4);
		sfix      = srem_s4 >= REM_W'(side_s4.mx);
		hrem_c    = hfix ? hrem_s4 - REM_W'(delta_s4) : hrem_s4;
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			din_s2  <= in_data;
			hrcp_s2 <= recip_tbl[in_data.delta];
			srcp_s2 <= recip_tbl[in_data.side.mx];
		end
		if (en_s3) begin
			hq0_s3   <= hprod[RCP_SHIFT +: HQ_W];
			sq0_s3   <= sprod[RCP_SHIFT +: CHAN_W];
			hnum_s3  <= din_s2.hnum;
			snum_s3  <= din_s2.snum;
			delta_s3 <= din_s2.delta;
			side_s3  <= din_s2.side;
		end
		if (en_s4) begin
			hq0_s4   <= hq0_s3;
			sq0_s4   <= sq0_s3;
			hrem_s4  <= hrem_full[REM_W-1:0];
			srem_s4  <= srem_full[REM_W-1:0];
			delta_s4 <= delta_s3;
			side_s4  <= side_s3;
		end
		if (en_s5) begin
			hq_s5    <= hq0_s4 + HQ_W'(hfix);
			sq_s5    <= sq0_s4 + CHAN_W'(sfix);
			hrem_s5  <= hrem_c;
			delta_s5 <= delta_s4;
			side_s5  <= side_s4;
		end
	end

	assign out_valid        = v_s5;
	assign out_data.hq      = hq_s5;
	assign out_data.hrem_nz = hrem_s5 != '0;
	assign out_data.sq      = sq_s5;
	assign out_data.side    = side_s5;

	`RHC_ASSERT_IMP(a_hue_quot_range, v_s5 && !side_s5.grey, hq_s5 <= HQ_W'(HUE_SECTOR),
		"hue quotient exceeds one sector")
	`RHC_ASSERT_IMP(a_hue_rem_range, v_s5 && !side_s5.grey, hrem_s5 < REM_W'(delta_s5),
		"hue remainder not below divisor after correction")
	`RHC_ASSERT_IMP(a_sat_nonzero, v_s5 && !side_s5.grey, sq_s5 != '0,
		"saturation quotient zero for a colored pixel")

endmodule
